// ===== rtl/core/block_descriptor_table_assert.svh =====
// ----------------------------------------------------------------------------
// Block descriptor table assertion macros
// Concurrent assertion wrappers for the block descriptor table design files.
// ----------------------------------------------------------------------------
`ifndef BLOCK_DESCRIPTOR_TABLE_ASSERT_SVH
`define BLOCK_DESCRIPTOR_TABLE_ASSERT_SVH

`ifndef SYNTHESIS
`define BDT_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");
`define BDT_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define BDT_ASSERT(label, clk, rst, prop)
`define BDT_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

// ===== rtl/core/bdt_pkg.sv =====
// ----------------------------------------------------------------------------
// Block descriptor table package
// Request, response and entry types, function and status codes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bdt_pkg;

   localparam logic [2:0] FUNC_ADD    = 3'd0;
   localparam logic [2:0] FUNC_REMOVE = 3'd1;
   localparam logic [2:0] FUNC_SEARCH = 3'd2;
   localparam logic [2:0] FUNC_FILE   = 3'd3;
   localparam logic [2:0] FUNC_RANGE  = 3'd4;

   localparam logic [1:0] STATUS_OK   = 2'd0;
   localparam logic [1:0] STATUS_NONE = 2'd1;
   localparam logic [1:0] STATUS_FULL = 2'd2;

   localparam int SLOT_W      = 5;
   localparam int MAX_RESULTS = 32;
   localparam int NRES_W      = 6;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_SHIFT,
      ST_FLUSH
   } state_type;

   typedef struct packed {
      logic [2:0]  func;
      logic [63:0] block_id_hi;
      logic [63:0] block_id_lo;
      logic [63:0] file_id_hi;
      logic [63:0] file_id_lo;
      logic [19:0] block_number;
      logic [63:0] iv_hi;
      logic [63:0] iv_lo;
      logic [31:0] range_offset;
      logic [31:0] range_size;
   } req_type;

   typedef struct packed {
      logic [1:0]        status;
      logic [SLOT_W-1:0] slot;
      logic [63:0]       out_block_id_hi;
      logic [63:0]       out_block_id_lo;
      logic [63:0]       out_file_id_hi;
      logic [63:0]       out_file_id_lo;
      logic [19:0]       out_block_number;
      logic [63:0]       out_iv_hi;
      logic [63:0]       out_iv_lo;
      logic              last;
   } rsp_type;

   typedef struct packed {
      logic [63:0] id_hi;
      logic [63:0] id_lo;
      logic [63:0] file_hi;
      logic [63:0] file_lo;
      logic [19:0] number;
      logic [63:0] iv_hi;
      logic [63:0] iv_lo;
   } entry_type;

endpackage

// ===== rtl/core/block_descriptor_table.sv =====
// Add and unknown functions answer straight from idle, without a scan; search,
// remove and file/range queries scan the entries, and remove then shifts the
// entries behind the removed one down a slot before it releases busy.
// One request at a time: busy is high while a scan, shift or flush runs.
// The single read port of the entry memory sets the pace: one entry per cycle.
// Reset clears the entry count and sequencer; results are strobed, no stall.
// ----------------------------------------------------------------------------
// Block descriptor table
// Ordered descriptor table with add, remove, search and file/range queries.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "block_descriptor_table_assert.svh"

module block_descriptor_table
   import bdt_pkg::*;
#(
   parameter int CAPACITY    = 32,
   parameter int BLOCK_BYTES = 4096
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_strobe,
   output rsp_type rsp_data
);

   localparam int IDX_W = $clog2(CAPACITY);
   localparam int CNT_W = IDX_W + 1;

   entry_type mem [CAPACITY];

   state_type          state_ff, state_in;
   req_type            req_ff, req_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [CNT_W-1:0]   addr_ff, addr_in;
   logic               rd_en, rd_vld_ff;
   logic [IDX_W-1:0]   rd_idx_ff;
   entry_type          rd_data_ff;
   logic               wr_en;
   logic [IDX_W-1:0]   wr_addr;
   entry_type          wr_data;
   logic               pend_vld_ff, pend_vld_in;
   entry_type          pend_ff, pend_in;
   logic [IDX_W-1:0]   pend_slot_ff, pend_slot_in;
   logic [NRES_W-1:0]  nres_ff, nres_in;
   rsp_type            rsp_ff, rsp_in;
   logic               strobe_ff, strobe_in;

   entry_type          req_entry;
   logic               is_id, is_file, in_range, qmatch, at_end;
   logic [32:0]        blk_start, blk_end, q_lo, q_hi;

   function automatic rsp_type make_rsp(logic [1:0] status, entry_type e,
                                        logic [IDX_W-1:0] idx, logic last);
      rsp_type                 r;
      logic [SLOT_W+IDX_W-1:0] ext;
      ext                = {{SLOT_W{1'b0}}, idx};
      r.status           = status;
      r.slot             = ext[SLOT_W-1:0];
      r.out_block_id_hi  = e.id_hi;
      r.out_block_id_lo  = e.id_lo;
      r.out_file_id_hi   = e.file_hi;
      r.out_file_id_lo   = e.file_lo;
      r.out_block_number = e.number;
      r.out_iv_hi        = e.iv_hi;
      r.out_iv_lo        = e.iv_lo;
      r.last             = last;
      return r;
   endfunction

   function automatic rsp_type empty_rsp(logic [1:0] status);
      rsp_type r;
      r        = '0;
      r.status = status;
      r.last   = 1'b1;
      return r;
   endfunction

   assign req_entry = '{id_hi: req_data.block_id_hi, id_lo: req_data.block_id_lo,
                        file_hi: req_data.file_id_hi, file_lo: req_data.file_id_lo,
                        number: req_data.block_number, iv_hi: req_data.iv_hi,
                        iv_lo: req_data.iv_lo};

   assign is_id   = (rd_data_ff.id_hi == req_ff.block_id_hi) &&
                    (rd_data_ff.id_lo == req_ff.block_id_lo);
   assign is_file = (rd_data_ff.file_hi == req_ff.file_id_hi) &&
                    (rd_data_ff.file_lo == req_ff.file_id_lo);
   assign blk_start = 33'(rd_data_ff.number) * 33'(BLOCK_BYTES);
   assign blk_end   = blk_start + 33'(BLOCK_BYTES);
   assign q_lo      = 33'(req_ff.range_offset);
   assign q_hi      = q_lo + 33'(req_ff.range_size);
   assign in_range  = (blk_start <= q_hi) && (blk_end >= q_lo);
   assign qmatch    = is_file && ((req_ff.func == FUNC_FILE) || in_range);
   assign at_end    = rd_vld_ff && ((CNT_W'(rd_idx_ff) + CNT_W'(1)) == count_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         count_ff    <= '0;
         rd_vld_ff   <= 1'b0;
         pend_vld_ff <= 1'b0;
         strobe_ff   <= 1'b0;
      end else begin
         state_ff    <= state_in;
         count_ff    <= count_in;
         rd_vld_ff   <= rd_en;
         pend_vld_ff <= pend_vld_in;
         strobe_ff   <= strobe_in;
      end
      req_ff       <= req_in;
      addr_ff      <= addr_in;
      pend_ff      <= pend_in;
      pend_slot_ff <= pend_slot_in;
      nres_ff      <= nres_in;
      rsp_ff       <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[addr_ff[IDX_W-1:0]];
         rd_idx_ff  <= addr_ff[IDX_W-1:0];
      end
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      count_in     = count_ff;
      addr_in      = addr_ff;
      rd_en        = 1'b0;
      wr_en        = 1'b0;
      wr_addr      = rd_idx_ff - IDX_W'(1);
      wr_data      = rd_data_ff;
      pend_vld_in  = pend_vld_ff;
      pend_in      = pend_ff;
      pend_slot_in = pend_slot_ff;
      nres_in      = nres_ff;
      rsp_in       = rsp_ff;
      strobe_in    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               req_in      = req_data;
               addr_in     = '0;
               nres_in     = '0;
               pend_vld_in = 1'b0;
               case (req_data.func)
                  FUNC_ADD: begin
                     strobe_in = 1'b1;
                     if (count_ff == CNT_W'(CAPACITY)) begin
                        rsp_in = empty_rsp(STATUS_FULL);
                     end else begin
                        wr_en    = 1'b1;
                        wr_addr  = count_ff[IDX_W-1:0];
                        wr_data  = req_entry;
                        count_in = count_ff + CNT_W'(1);
                        rsp_in   = make_rsp(STATUS_OK, req_entry,
                                            count_ff[IDX_W-1:0], 1'b1);
                     end
                  end
                  FUNC_REMOVE, FUNC_SEARCH, FUNC_FILE, FUNC_RANGE: begin
                     if (count_ff == '0) begin
                        strobe_in = 1'b1;
                        rsp_in    = empty_rsp(STATUS_NONE);
                     end else begin
                        state_in = ST_SCAN;
                     end
                  end
                  default: begin
                     strobe_in = 1'b1;
                     rsp_in    = empty_rsp(STATUS_NONE);
                  end
               endcase
            end
         end
         ST_SCAN: begin
            rd_en = addr_ff < count_ff;
            if (rd_vld_ff) begin
               if ((req_ff.func == FUNC_REMOVE) || (req_ff.func == FUNC_SEARCH)) begin
                  if (is_id) begin
                     strobe_in = 1'b1;
                     rsp_in    = make_rsp(STATUS_OK, rd_data_ff, rd_idx_ff, 1'b1);
                     rd_en     = 1'b0;
                     if (req_ff.func == FUNC_SEARCH) begin
                        state_in = ST_IDLE;
                     end else if (at_end) begin
                        count_in = count_ff - CNT_W'(1);
                        state_in = ST_IDLE;
                     end else begin
                        addr_in  = CNT_W'(rd_idx_ff) + CNT_W'(1);
                        state_in = ST_SHIFT;
                     end
                  end else if (at_end) begin
                     strobe_in = 1'b1;
                     rsp_in    = empty_rsp(STATUS_NONE);
                     rd_en     = 1'b0;
                     state_in  = ST_IDLE;
                  end
               end else begin
                  if (qmatch) begin
                     if (pend_vld_ff) begin
                        strobe_in = 1'b1;
                        rsp_in    = make_rsp(STATUS_OK, pend_ff, pend_slot_ff, 1'b0);
                     end
                     pend_vld_in  = 1'b1;
                     pend_in      = rd_data_ff;
                     pend_slot_in = rd_idx_ff;
                     nres_in      = nres_ff + NRES_W'(1);
                  end
                  if (at_end || (qmatch && (nres_ff == NRES_W'(MAX_RESULTS - 1)))) begin
                     rd_en    = 1'b0;
                     state_in = ST_FLUSH;
                  end
               end
            end
            if (rd_en) begin
               addr_in = addr_ff + CNT_W'(1);
            end
         end
         ST_SHIFT: begin
            rd_en = addr_ff < count_ff;
            if (rd_vld_ff) begin
               wr_en = 1'b1;
               if (at_end) begin
                  rd_en    = 1'b0;
                  count_in = count_ff - CNT_W'(1);
                  state_in = ST_IDLE;
               end
            end
            if (rd_en) begin
               addr_in = addr_ff + CNT_W'(1);
            end
         end
         ST_FLUSH: begin
            strobe_in   = 1'b1;
            pend_vld_in = 1'b0;
            state_in    = ST_IDLE;
            if (pend_vld_ff) begin
               rsp_in = make_rsp(STATUS_OK, pend_ff, pend_slot_ff, 1'b1);
            end else begin
               rsp_in = empty_rsp(STATUS_NONE);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy       = state_ff != ST_IDLE;
   assign rsp_strobe = strobe_ff;
   assign rsp_data   = rsp_ff;

   `BDT_ASSERT(a_count_bound, clock, reset, count_ff <= CNT_W'(CAPACITY))
   `BDT_ASSERT(a_pend_state, clock, reset,
      pend_vld_ff |-> ((state_ff == ST_SCAN) || (state_ff == ST_FLUSH)))
   `BDT_ASSERT(a_full_status, clock, reset,
      (strobe_ff && (rsp_ff.status == STATUS_FULL)) |-> (count_ff == CNT_W'(CAPACITY)))
   `BDT_ASSERT(a_write_in_range, clock, reset,
      wr_en |-> (CNT_W'(wr_addr) < CNT_W'(CAPACITY)))

endmodule

// ===== dv/testbench.sv =====
// ----------------------------------------------------------------------------
// Block descriptor table testbench
// Drives add, remove, search, file and range requests, plus unknown function
// codes, through the start/busy handshake. A directed table runs first, then
// random traffic over a small pool of ids and files so that matches, table
// full and long query answers occur. Every strobed response is checked field
// by field against a local model of the table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench
   import bdt_pkg::*;
();

   localparam int DEPTH      = 32;
   localparam int BLK_BYTES  = 4096;
   localparam int CYCLE_CAP  = 400000;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_strobe;
   rsp_type rsp_data;

   block_descriptor_table dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_strobe(rsp_strobe), .rsp_data(rsp_data)
   );

   entry_type table_q[$];
   rsp_type   pending_rsp[$];
   int        error_count;
   int        cycle_count;
   int        idle_pct;

   typedef struct {
      req_type req;
      logic    typed;
      rsp_type rsp;
   } row_type;
   row_type rows[$];

   logic [63:0] id_pool [8];
   logic [63:0] file_pool [3];

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic rsp_type make_rsp(logic [1:0] st, int pos, logic lst);
      rsp_type r;
      r = '0;
      r.status = st;
      if (pos >= 0) begin
         r.slot             = pos[SLOT_W-1:0];
         r.out_block_id_hi  = table_q[pos].id_hi;
         r.out_block_id_lo  = table_q[pos].id_lo;
         r.out_file_id_hi   = table_q[pos].file_hi;
         r.out_file_id_lo   = table_q[pos].file_lo;
         r.out_block_number = table_q[pos].number;
         r.out_iv_hi        = table_q[pos].iv_hi;
         r.out_iv_lo        = table_q[pos].iv_lo;
      end
      r.last = lst;
      return r;
   endfunction

   task automatic predict_table(input req_type q);
      entry_type e;
      int pos;
      int n;
      logic [32:0] qlo, qhi;
      logic [32:0] bs, be;
      pos = -1;
      n = 0;
      case (q.func)
         FUNC_ADD: begin
            if (table_q.size() >= DEPTH) begin
               pending_rsp.push_back(make_rsp(STATUS_FULL, -1, 1'b1));
            end else begin
               e.id_hi = q.block_id_hi;  e.id_lo = q.block_id_lo;
               e.file_hi = q.file_id_hi; e.file_lo = q.file_id_lo;
               e.number = q.block_number;
               e.iv_hi = q.iv_hi;        e.iv_lo = q.iv_lo;
               table_q.push_back(e);
               pending_rsp.push_back(make_rsp(STATUS_OK, table_q.size() - 1, 1'b1));
            end
         end
         FUNC_REMOVE, FUNC_SEARCH: begin
            foreach (table_q[i])
               if (pos < 0 && table_q[i].id_hi == q.block_id_hi &&
                   table_q[i].id_lo == q.block_id_lo) pos = i;
            if (pos < 0) begin
               pending_rsp.push_back(make_rsp(STATUS_NONE, -1, 1'b1));
            end else begin
               pending_rsp.push_back(make_rsp(STATUS_OK, pos, 1'b1));
               if (q.func == FUNC_REMOVE) table_q.delete(pos);
            end
         end
         FUNC_FILE, FUNC_RANGE: begin
            qlo = {1'b0, q.range_offset};
            qhi = qlo + {1'b0, q.range_size};
            foreach (table_q[i]) begin
               if (table_q[i].file_hi == q.file_id_hi && table_q[i].file_lo == q.file_id_lo
                   && n < MAX_RESULTS) begin
                  bs = 33'(table_q[i].number) * BLK_BYTES;
                  be = bs + BLK_BYTES;
                  if (q.func == FUNC_FILE || (bs <= qhi && be >= qlo)) begin
                     pending_rsp.push_back(make_rsp(STATUS_OK, i, 1'b0));
                     n++;
                  end
               end
            end
            if (n == 0) pending_rsp.push_back(make_rsp(STATUS_NONE, -1, 1'b1));
            else pending_rsp[pending_rsp.size() - 1].last = 1'b1;
         end
         default: begin
            pending_rsp.push_back(make_rsp(STATUS_NONE, -1, 1'b1));
         end
      endcase
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         cycle_count <= cycle_count + 1;
         if (rsp_strobe) begin
            if (pending_rsp.size() == 0) begin
               $display("%0t: unexpected response %h", $time, rsp_data);
               error_count <= error_count + 1;
            end else begin
               want = pending_rsp.pop_front();
               if (rsp_data !== want) begin
                  $display("%0t: mismatch expected %h actual %h", $time, want, rsp_data);
                  error_count <= error_count + 1;
               end
            end
         end
      end
   end

   initial begin
      wait (cycle_count >= CYCLE_CAP);
      $display("testbench: done, errors");
      $finish;
   end

   function automatic req_type rand_req(int mode);
      req_type q;
      q = '0;
      q.func = (mode == 0) ? 3'($urandom_range(0, 7)) : 3'($urandom_range(0, 4));
      if ($urandom_range(0, 3) != 0 && q.func <= FUNC_SEARCH && q.func != FUNC_ADD) begin
         q.block_id_hi = id_pool[$urandom_range(0, 7)];
         q.block_id_lo = ~q.block_id_hi;
      end else if (q.func == FUNC_ADD && $urandom_range(0, 4) != 0) begin
         q.block_id_hi = id_pool[$urandom_range(0, 7)];
         q.block_id_lo = ~q.block_id_hi;
      end else begin
         q.block_id_hi = {$urandom, $urandom};
         q.block_id_lo = {$urandom, $urandom};
      end
      if ($urandom_range(0, 5) != 0) begin
         q.file_id_hi = file_pool[$urandom_range(0, 2)];
         q.file_id_lo = q.file_id_hi ^ 64'h5a5a;
      end else begin
         q.file_id_hi = {$urandom, $urandom};
         q.file_id_lo = {$urandom, $urandom};
      end
      q.block_number = ($urandom_range(0, 9) == 0) ? 20'($urandom) : 20'($urandom_range(0, 15));
      q.iv_hi = {$urandom, $urandom};
      q.iv_lo = {$urandom, $urandom};
      if ($urandom_range(0, 4) == 0) begin
         q.range_offset = $urandom;
         q.range_size   = $urandom;
      end else begin
         q.range_offset = $urandom_range(0, 65535);
         q.range_size   = $urandom_range(0, 8192);
      end
      return q;
   endfunction

   // Busy is sampled on the falling edge, so the request is accepted at the
   // rising edge that follows the one where start is raised.
   task automatic send_request(input req_type q, input logic typed, input rsp_type want);
      @(negedge clock);
      while (busy) @(negedge clock);
      @(posedge clock);
      if (typed) pending_rsp.push_back(want);
      else predict_table(q);
      start    <= 1'b1;
      req_data <= q;
      @(posedge clock);
      start    <= 1'b0;
   endtask

   task automatic settle;
      int guard;
      guard = 0;
      while ((pending_rsp.size() != 0 || busy) && guard < 2000) begin
         @(posedge clock);
         guard++;
      end
      repeat (4) @(posedge clock);
   endtask

   initial begin
      row_type r;
      req_type q;
      rsp_type full_rsp;
      int      pick;
      error_count = 0;
      cycle_count = 0;
      reset    = 1'b1;
      start    = 1'b0;
      req_data = '0;
      idle_pct = 0;
      foreach (id_pool[i]) id_pool[i] = {$urandom, $urandom};
      id_pool[0] = '0;
      id_pool[1] = '1;
      foreach (file_pool[i]) file_pool[i] = {$urandom, $urandom};
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed table; typed rows carry their expected answers directly.
      r.typed = 1'b1;
      r.rsp = '0; r.rsp.status = STATUS_NONE; r.rsp.last = 1'b1;
      r.req = '0; r.req.func = FUNC_SEARCH;   rows.push_back(r);
      r.req = '0; r.req.func = FUNC_REMOVE;   rows.push_back(r);
      r.req = '0; r.req.func = FUNC_FILE;     rows.push_back(r);
      r.req = '1; r.req.func = FUNC_RANGE;    rows.push_back(r);
      r.req = '1; r.req.func = 3'd5;          rows.push_back(r);
      r.req = '1;                             rows.push_back(r);
      r.typed = 1'b0;
      r.req = '1; r.req.func = FUNC_ADD;      rows.push_back(r);
      r.req = '0;                             rows.push_back(r);
      r.req = '1; r.req.func = FUNC_ADD; r.req.block_number = 20'd0; rows.push_back(r);
      r.req = '1; r.req.func = FUNC_FILE;     rows.push_back(r);
      // Range inside block 0, touching its inclusive end, past it, and at maximum.
      r.req.func = FUNC_RANGE; r.req.range_offset = 32'd100; r.req.range_size = 32'd5;
      rows.push_back(r);
      r.req.range_offset = 32'd4096; r.req.range_size = 32'd0; rows.push_back(r);
      r.req.range_offset = 32'd4097; r.req.range_size = 32'd0; rows.push_back(r);
      r.req.range_offset = '1; r.req.range_size = '1; rows.push_back(r);
      r.req = '1; r.req.func = FUNC_SEARCH;   rows.push_back(r);
      r.req = '1; r.req.func = FUNC_REMOVE;   rows.push_back(r);
      r.req = '1; r.req.func = FUNC_REMOVE;   rows.push_back(r);
      r.req = '1; r.req.func = 3'd6;          rows.push_back(r);
      foreach (rows[i]) begin
         send_request(rows[i].req, rows[i].typed, rows[i].rsp);
         settle();
      end
      // Table full and an add refused, then a file query over the filled entries.
      while (table_q.size() < DEPTH) begin
         q = rand_req(1); q.func = FUNC_ADD;
         q.file_id_hi = file_pool[0]; q.file_id_lo = file_pool[0] ^ 64'h5a5a;
         send_request(q, 1'b0, '0);
      end
      settle();
      full_rsp = '0; full_rsp.status = STATUS_FULL; full_rsp.last = 1'b1;
      q = rand_req(1); q.func = FUNC_ADD;
      send_request(q, 1'b1, full_rsp);
      settle();
      q.func = FUNC_FILE; q.file_id_hi = file_pool[0]; q.file_id_lo = file_pool[0] ^ 64'h5a5a;
      send_request(q, 1'b0, '0);
      settle();
      while (table_q.size() > 4) begin
         pick = $urandom_range(0, table_q.size() - 1);
         q = '0; q.func = FUNC_REMOVE;
         q.block_id_hi = table_q[pick].id_hi;
         q.block_id_lo = table_q[pick].id_lo;
         send_request(q, 1'b0, '0);
      end
      settle();

      for (int phase = 0; phase < 4; phase++) begin
         idle_pct = (phase == 1) ? 72 : (phase == 3) ? 6 : 0;
         for (int k = 0; k < 25; k++) begin
            while (idle_pct != 0 && $urandom_range(1, 100) <= idle_pct) begin
               @(posedge clock);
            end
            q = rand_req(k % 6 == 0 ? 0 : 1);
            if (q.func == FUNC_ADD && table_q.size() > 24 && $urandom_range(0, 2) != 0)
               q.func = FUNC_REMOVE;
            send_request(q, 1'b0, '0);
         end
      end
      settle();
      repeat (80) @(posedge clock);
      if (error_count == 0 && pending_rsp.size() == 0) begin
         $display("testbench: done, clean");
      end else begin
         $display("testbench: done, errors");
      end
      $finish;
   end

endmodule

// ===== block_descriptor_table.f =====
+incdir+rtl/core
rtl/core/bdt_pkg.sv
rtl/core/block_descriptor_table.sv
dv/testbench.sv
